[hdl/arenv_pkg.sv]
// Shared constants and types for the attack/release envelope follower.
package arenv_pkg;

   localparam int unsigned CSR_INDEX_BITS = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_COEF_ATTACK     = 2'd0,
      CSR_COEF_DECAY      = 2'd1,
      CSR_STEREO_MODE     = 2'd2,
      CSR_SLEEP_THRESHOLD = 2'd3
   } csr_index_type;

   localparam int unsigned SLEEP_THRESHOLD_RESET = 8389;
   localparam logic        STEREO_MODE_RESET     = 1'b1;

endpackage

[hdl/attack_release_envelope_follower_unit.sv]
// Attack/release envelope follower: input register, one-pole update, result register.
//
//  channel | direction | handshake                | payload
//  req     | in        | req_tvalid / req_tready  | tdata {sample_right, sample_left}, tlast
//  rsp     | out       | rsp_tvalid / rsp_tready  | tdata {block_peak, envelope}, tlast, tuser
//  csr     | in        | csr_wr_en                | csr_index, csr_wdata
//
// One request per cycle while the result is not stalled; an accepted request passes through the
// input register and then the result register, which raises rsp_tvalid.
// The envelope recurrence (compare, multiply, add) closes in the single compute stage.
// Synchronous active-high reset clears envelope, mode, block peak and valids, and loads
// the configuration reset values.
// A stalled result holds; the input register takes one more request, then req_tready
// stays low until the result register is freed.
module attack_release_envelope_follower_unit #(
   parameter int unsigned SAMPLE_BITS = 24,
   parameter int unsigned COEF_BITS   = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // sample_left, sample_right, zero pad
   input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]      req_tdata,
   // last_in_block
   input  logic                                    req_tlast,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // envelope, block_peak, zero pad
   output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]      rsp_tdata,
   // peak_valid
   output logic                                    rsp_tlast,
   // sleepy
   output logic                                    rsp_tuser,
   input  logic                                    csr_wr_en,
   input  logic [arenv_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [((SAMPLE_BITS > COEF_BITS) ? SAMPLE_BITS : COEF_BITS)-1:0] csr_wdata
);

   localparam int unsigned DATA_BITS = ((2*SAMPLE_BITS+7)/8)*8;

   // configuration
   logic [COEF_BITS-1:0]   coef_attack_ff;
   logic [COEF_BITS-1:0]   coef_decay_ff;
   logic                   stereo_mode_ff;
   logic [SAMPLE_BITS-1:0] sleep_threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_attack_ff     <= '0;
         coef_decay_ff      <= '0;
         stereo_mode_ff     <= arenv_pkg::STEREO_MODE_RESET;
         sleep_threshold_ff <= SAMPLE_BITS'(arenv_pkg::SLEEP_THRESHOLD_RESET);
      end else if (csr_wr_en) begin
         case (arenv_pkg::csr_index_type'(csr_index))
            arenv_pkg::CSR_COEF_ATTACK:     coef_attack_ff     <= csr_wdata[COEF_BITS-1:0];
            arenv_pkg::CSR_COEF_DECAY:      coef_decay_ff      <= csr_wdata[COEF_BITS-1:0];
            arenv_pkg::CSR_STEREO_MODE:     stereo_mode_ff     <= csr_wdata[0];
            arenv_pkg::CSR_SLEEP_THRESHOLD: sleep_threshold_ff <= csr_wdata[SAMPLE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // handshake
   logic                   stage_valid_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_load;
   logic                   stage_load;

   assign rsp_load   = stage_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !stage_valid_ff || rsp_load;
   assign stage_load = req_tvalid && req_tready;

   // input register
   logic signed [SAMPLE_BITS-1:0] left_ff;
   logic signed [SAMPLE_BITS-1:0] right_ff;
   logic                          last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_load || (stage_valid_ff && !rsp_load);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_load) begin
         left_ff  <= $signed(req_tdata[SAMPLE_BITS-1:0]);
         right_ff <= $signed(req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
         last_ff  <= req_tlast;
      end
   end

   // envelope update
   logic [SAMPLE_BITS-1:0]              envelope_ff;
   logic                                attack_mode_ff;
   logic [SAMPLE_BITS-1:0]              running_peak_ff;

   logic signed [SAMPLE_BITS:0]         mid_sum;
   logic signed [SAMPLE_BITS-1:0]       sample_sel;
   logic [SAMPLE_BITS-1:0]              magnitude;
   logic                                attack_mode_in;
   logic [COEF_BITS-1:0]                coef_sel;
   logic signed [SAMPLE_BITS:0]         env_diff;
   logic signed [SAMPLE_BITS+COEF_BITS+1:0] product;
   logic signed [SAMPLE_BITS+COEF_BITS+1:0] product_scaled;
   logic [SAMPLE_BITS-1:0]              envelope_in;
   logic [SAMPLE_BITS-1:0]              block_peak;
   logic [SAMPLE_BITS-1:0]              running_peak_in;
   logic                                sleepy;

   always_comb begin
      mid_sum    = {left_ff[SAMPLE_BITS-1], left_ff} + {right_ff[SAMPLE_BITS-1], right_ff};
      sample_sel = stereo_mode_ff ? mid_sum[SAMPLE_BITS:1] : left_ff;
      magnitude  = sample_sel[SAMPLE_BITS-1] ? (~sample_sel + 1'b1) : sample_sel;

      if (attack_mode_ff) begin
         attack_mode_in = !(envelope_ff > magnitude);
      end else begin
         attack_mode_in = envelope_ff < magnitude;
      end
      coef_sel = attack_mode_in ? coef_attack_ff : coef_decay_ff;

      env_diff       = $signed({1'b0, envelope_ff}) - $signed({1'b0, magnitude});
      product        = $signed({1'b0, coef_sel}) * env_diff;
      product_scaled = product >>> COEF_BITS;
      envelope_in    = magnitude + product_scaled[SAMPLE_BITS-1:0];

      block_peak      = (envelope_in > running_peak_ff) ? envelope_in : running_peak_ff;
      running_peak_in = last_ff ? '0 : block_peak;
      sleepy          = !attack_mode_in && (envelope_in < sleep_threshold_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         envelope_ff     <= '0;
         attack_mode_ff  <= 1'b0;
         running_peak_ff <= '0;
      end else if (rsp_load) begin
         envelope_ff     <= envelope_in;
         attack_mode_ff  <= attack_mode_in;
         running_peak_ff <= running_peak_in;
      end
   end

   // result register
   logic [SAMPLE_BITS-1:0] rsp_envelope_ff;
   logic [SAMPLE_BITS-1:0] rsp_peak_ff;
   logic                   rsp_last_ff;
   logic                   rsp_sleepy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && !rsp_tready);
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_envelope_ff <= envelope_in;
         rsp_peak_ff     <= block_peak;
         rsp_last_ff     <= last_ff;
         rsp_sleepy_ff   <= sleepy;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_BITS'({rsp_peak_ff, rsp_envelope_ff});
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_sleepy_ff;

endmodule

[hdl/arenv_checker.sv]
// Port-level checks for the envelope follower, bound to the top level.
module arenv_checker #(
   parameter int unsigned SAMPLE_BITS = 24
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [((2*SAMPLE_BITS+7)/8)*8-1:0]  rsp_tdata
);

   logic [SAMPLE_BITS-1:0] envelope;
   logic [SAMPLE_BITS-1:0] block_peak;
   logic [SAMPLE_BITS-1:0] full_scale;

   assign envelope   = rsp_tdata[SAMPLE_BITS-1:0];
   assign block_peak = rsp_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
   assign full_scale = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   a_env_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> envelope <= full_scale)
      else $error("envelope above full scale");

   a_peak_covers_env: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> block_peak >= envelope)
      else $error("block peak below envelope");

   a_reset_clears: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

bind attack_release_envelope_follower_unit arenv_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_arenv_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
